// File: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation and status codes,
// sequencer states and the shared-divider command and response structs. No dependencies.
package rau_pkg;

    localparam int DataWidth = 32;
    localparam int MagWidth  = 2 * DataWidth;
    localparam int CntWidth  = $clog2(MagWidth + 1);

    typedef logic [MagWidth-1:0] mag_t;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_RED = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_WIDE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_CHECK,
        S_GCD_START,
        S_GCD_WAIT,
        S_DIVN_START,
        S_DIVN_WAIT,
        S_DIVD_START,
        S_DIVD_WAIT,
        S_FINISH,
        S_OUT
    } state_t;

    // command to the shared divider
    typedef struct packed {
        logic start;
        mag_t dividend;
        mag_t divisor;
    } div_cmd_t;

    typedef struct packed {
        logic done;
        mag_t quot;
        mag_t rem;
    } div_rsp_t;

endpackage

// File: rtl/core/rau_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_cmd_t cmd,
    output rau_pkg::div_rsp_t rsp
);

    rau_pkg::mag_t                 quot_reg, quot_next;
    rau_pkg::mag_t                 rem_reg, rem_next;
    rau_pkg::mag_t                 dvs_reg, dvs_next;
    logic [rau_pkg::CntWidth-1:0]  cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rau_pkg::MagWidth:0]    trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[rau_pkg::MagWidth-1]} - {1'b0, dvs_reg};
        if (cmd.start)
        begin
            quot_next = cmd.dividend;
            rem_next  = '0;
            dvs_next  = cmd.divisor;
            cnt_next  = rau_pkg::CntWidth'(rau_pkg::MagWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[rau_pkg::MagWidth])
            begin
                rem_next = trial[rau_pkg::MagWidth-1:0];
                quot_next = {quot_reg[rau_pkg::MagWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[rau_pkg::MagWidth-2:0], quot_reg[rau_pkg::MagWidth-1]};
                quot_next = {quot_reg[rau_pkg::MagWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rau_pkg::CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy_reg) else $error("divider did not start");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !cmd.start) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider count skipped");
`endif

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: one item at a time. A shared 32x32 multiplier forms
// the cross products in states S_MUL1 to S_MUL3, then a 64-bit bit-serial
// divider runs the Euclidean GCD, one remainder per pass, and two exact
// divisions. in_ready is low from acceptance until the result has been taken.
// Depends on rau_pkg and rau_divider.
module rational_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0] res_den,
    output logic [1:0]  status
);

    localparam int W = rau_pkg::DataWidth;
    localparam int M = rau_pkg::MagWidth;

    rau_pkg::state_t  state_reg, state_next;
    logic [2:0]       func_reg;
    logic [W-1:0]     an_reg, ad_reg, bn_reg, bd_reg;
    logic             ann_reg, adn_reg, bnn_reg, bdn_reg;
    rau_pkg::mag_t    p0_reg, p1_reg, p2_reg;
    logic             p0n_reg, p1n_reg, p2n_reg;
    rau_pkg::mag_t    n_reg, d_reg, x_reg, y_reg, g_reg, nm_reg;
    logic             nn_reg, dn_reg;
    logic [31:0]      rn_reg;
    logic [30:0]      rd_reg;
    rau_pkg::status_t st_reg;

    rau_pkg::div_cmd_t cmd;
    rau_pkg::div_rsp_t rsp;

    logic [W-1:0]     mx, my;
    rau_pkg::mag_t    prod;
    logic             prod_neg;
    logic             is_mul, is_div, is_addsub;
    rau_pkg::mag_t    limit;
    logic             t_neg;
    logic             neg;

    function automatic logic [W-1:0] mag_of(input logic [31:0] v);
        logic [W-1:0] x;
        x = v[W-1:0];
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    assign is_mul    = (func_reg == rau_pkg::FUNC_MUL);
    assign is_div    = (func_reg == rau_pkg::FUNC_DIV);
    assign is_addsub = (func_reg == rau_pkg::FUNC_ADD) || (func_reg == rau_pkg::FUNC_SUB);
    assign limit     = (M'(1) << (W - 1)) - 1'b1;
    assign neg       = nn_reg != dn_reg;
    assign t_neg     = p1n_reg ^ (func_reg == rau_pkg::FUNC_SUB);

    // shared multiplier operand select
    always_comb
    begin
        mx = an_reg;
        my = bd_reg;
        prod_neg = ann_reg != bdn_reg;
        case (state_reg)
            rau_pkg::S_MUL1:
            begin
                mx = an_reg;
                my = is_mul ? bn_reg : bd_reg;
                prod_neg = ann_reg != (is_mul ? bnn_reg : bdn_reg);
            end
            rau_pkg::S_MUL2:
            begin
                mx = bn_reg;
                my = ad_reg;
                prod_neg = bnn_reg != adn_reg;
            end
            rau_pkg::S_MUL3:
            begin
                mx = ad_reg;
                my = is_div ? bn_reg : bd_reg;
                prod_neg = adn_reg != (is_div ? bnn_reg : bdn_reg);
            end
            default:
            begin
                mx = an_reg;
                my = bd_reg;
                prod_neg = 1'b0;
            end
        endcase
        prod = M'(mx) * M'(my);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::S_IDLE:       if (in_valid) state_next = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:       state_next = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:       state_next = rau_pkg::S_MUL3;
            rau_pkg::S_MUL3:       state_next = rau_pkg::S_SUM;
            rau_pkg::S_SUM:        state_next = rau_pkg::S_CHECK;
            rau_pkg::S_CHECK:
            begin
                if (d_reg == '0 || n_reg == '0) state_next = rau_pkg::S_OUT;
                else                            state_next = rau_pkg::S_GCD_START;
            end
            rau_pkg::S_GCD_START:
            begin
                if (x_reg == '0 || y_reg == '0) state_next = rau_pkg::S_DIVN_START;
                else                            state_next = rau_pkg::S_GCD_WAIT;
            end
            rau_pkg::S_GCD_WAIT:   if (rsp.done) state_next = rau_pkg::S_GCD_START;
            rau_pkg::S_DIVN_START: state_next = rau_pkg::S_DIVN_WAIT;
            rau_pkg::S_DIVN_WAIT:  if (rsp.done) state_next = rau_pkg::S_DIVD_START;
            rau_pkg::S_DIVD_START: state_next = rau_pkg::S_DIVD_WAIT;
            rau_pkg::S_DIVD_WAIT:  if (rsp.done) state_next = rau_pkg::S_FINISH;
            rau_pkg::S_FINISH:     state_next = rau_pkg::S_OUT;
            rau_pkg::S_OUT:        if (out_ready) state_next = rau_pkg::S_IDLE;
            default:               state_next = rau_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == rau_pkg::S_IDLE);
        out_valid = (state_reg == rau_pkg::S_OUT);
        cmd.start = 1'b0;
        cmd.dividend = x_reg;
        cmd.divisor  = y_reg;
        case (state_reg)
            rau_pkg::S_GCD_START:
            begin
                cmd.start = (x_reg != '0) && (y_reg != '0);
                cmd.dividend = (x_reg > y_reg) ? x_reg : y_reg;
                cmd.divisor  = (x_reg > y_reg) ? y_reg : x_reg;
            end
            rau_pkg::S_DIVN_START:
            begin
                cmd.start = 1'b1;
                cmd.dividend = n_reg;
                cmd.divisor  = g_reg;
            end
            rau_pkg::S_DIVD_START:
            begin
                cmd.start = 1'b1;
                cmd.dividend = d_reg;
                cmd.divisor  = g_reg;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    rau_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= rau_pkg::S_IDLE;
        else        state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                func_reg <= func;
                an_reg <= mag_of(a_num); ann_reg <= a_num[W-1];
                ad_reg <= mag_of(a_den); adn_reg <= a_den[W-1];
                bn_reg <= mag_of(b_num); bnn_reg <= b_num[W-1];
                bd_reg <= mag_of(b_den); bdn_reg <= b_den[W-1];
            end
            rau_pkg::S_MUL1: begin p0_reg <= prod; p0n_reg <= prod_neg; end
            rau_pkg::S_MUL2: begin p1_reg <= prod; p1n_reg <= prod_neg; end
            rau_pkg::S_MUL3: begin p2_reg <= prod; p2n_reg <= prod_neg; end
            rau_pkg::S_SUM:
            begin
                if (is_addsub)
                begin
                    if (p0n_reg == t_neg)
                    begin
                        n_reg <= p0_reg + p1_reg; nn_reg <= p0n_reg;
                    end
                    else if (p0_reg >= p1_reg)
                    begin
                        n_reg <= p0_reg - p1_reg; nn_reg <= p0n_reg;
                    end
                    else
                    begin
                        n_reg <= p1_reg - p0_reg; nn_reg <= t_neg;
                    end
                    d_reg <= p2_reg; dn_reg <= p2n_reg;
                end
                else if (is_mul || is_div)
                begin
                    n_reg <= p0_reg; nn_reg <= p0n_reg;
                    d_reg <= p2_reg; dn_reg <= p2n_reg;
                end
                else
                begin
                    n_reg <= M'(an_reg); nn_reg <= ann_reg;
                    d_reg <= M'(ad_reg); dn_reg <= adn_reg;
                end
                rn_reg <= '0;
                rd_reg <= 31'd1;
                st_reg <= rau_pkg::ST_OK;
            end
            rau_pkg::S_CHECK:
            begin
                x_reg <= n_reg;
                y_reg <= d_reg;
                if (d_reg == '0) st_reg <= rau_pkg::ST_ZDEN;
            end
            rau_pkg::S_GCD_START:
            begin
                g_reg <= x_reg + y_reg;
            end
            rau_pkg::S_GCD_WAIT:
            begin
                if (rsp.done)
                begin
                    if (x_reg > y_reg) x_reg <= rsp.rem;
                    else               y_reg <= rsp.rem;
                end
            end
            rau_pkg::S_DIVN_WAIT: if (rsp.done) nm_reg <= rsp.quot;
            rau_pkg::S_FINISH:
            begin
                if ((neg ? (nm_reg <= limit + 1'b1) : (nm_reg <= limit))
                    && rsp.quot <= limit)
                begin
                    rn_reg <= 32'(neg ? (M'(0) - nm_reg) : nm_reg);
                    rd_reg <= 31'(rsp.quot);
                end
                else
                begin
                    st_reg <= rau_pkg::ST_WIDE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign status  = st_reg;

`ifndef SYNTH
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(res_num))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != rau_pkg::ST_OK) |-> (res_num == 0 && res_den == 31'd1))
        else $error("error result not 0/1");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
`endif

endmodule

// File: dv/rational_arithmetic_unit_test.sv
// Testbench for rational_arithmetic_unit: directed and random fraction operations,
// checked against an in-bench predictor. Depends on rau_pkg and the RTL.
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;

    localparam int unsigned CycleLimit = 20_000_000;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } smag_t;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        rau_pkg::status_t   st;
    } fraction_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] func;
    logic signed [31:0] a_num, a_den, b_num, b_den;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0] status;

    fraction_t expected_fractions[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_cycles;
    int unsigned error_count;

    rational_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic smag_t to_smag(logic [31:0] v);
        smag_t r;
        r.neg = v[31];
        r.mag = {32'd0, v[31] ? (~v + 32'd1) : v};
        return r;
    endfunction

    function automatic smag_t smag_mul(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && (r.mag != 0);
        return r;
    endfunction

    function automatic smag_t smag_add(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end
        else if (x.mag >= y.mag)
        begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end
        else
        begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic fraction_t compute_fraction(logic [2:0] f, logic [31:0] an,
                                                   logic [31:0] ad, logic [31:0] bn,
                                                   logic [31:0] bd);
        smag_t n, d, t;
        logic [63:0] x, y, nm, dm;
        logic [63:0] limit;
        bit neg, fits;
        fraction_t r;
        limit = 64'h7FFF_FFFF;
        r.num = '0;
        r.den = 31'd1;
        r.st  = rau_pkg::ST_OK;
        case (f)
            rau_pkg::FUNC_ADD:
            begin
                n = smag_add(smag_mul(to_smag(an), to_smag(bd)),
                             smag_mul(to_smag(bn), to_smag(ad)));
                d = smag_mul(to_smag(ad), to_smag(bd));
            end
            rau_pkg::FUNC_SUB:
            begin
                t = smag_mul(to_smag(bn), to_smag(ad));
                if (t.mag != 0)
                    t.neg = !t.neg;
                n = smag_add(smag_mul(to_smag(an), to_smag(bd)), t);
                d = smag_mul(to_smag(ad), to_smag(bd));
            end
            rau_pkg::FUNC_MUL:
            begin
                n = smag_mul(to_smag(an), to_smag(bn));
                d = smag_mul(to_smag(ad), to_smag(bd));
            end
            rau_pkg::FUNC_DIV:
            begin
                n = smag_mul(to_smag(an), to_smag(bd));
                d = smag_mul(to_smag(ad), to_smag(bn));
            end
            default:
            begin
                n = to_smag(an);
                d = to_smag(ad);
            end
        endcase
        if (d.mag == 0)
            r.st = rau_pkg::ST_ZDEN;
        else if (n.mag != 0)
        begin
            x = n.mag;
            y = d.mag;
            while (x != 0 && y != 0)
            begin
                if (x > y)
                    x = x % y;
                else
                    y = y % x;
            end
            nm = n.mag / (x + y);
            dm = d.mag / (x + y);
            neg = n.neg != d.neg;
            fits = (neg ? nm <= limit + 1 : nm <= limit) && dm <= limit;
            if (fits)
            begin
                r.num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
                r.den = dm[30:0];
            end
            else
                r.st = rau_pkg::ST_WIDE;
        end
        return r;
    endfunction

    // Call at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func  <= f;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_fractions.push_back(compute_fraction(f, an, ad, bn, bd));
    endtask

    // Result checker and receiver stall generator
    initial
    begin
        fraction_t exp_f;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_fractions.size() == 0)
                begin
                    $error("unexpected result %0d/%0d status %0d", res_num, res_den, status);
                    error_count++;
                end
                else
                begin
                    exp_f = expected_fractions.pop_front();
                    if (res_num !== exp_f.num)
                    begin
                        $error("res_num: expected %0d, actual %0d", exp_f.num, res_num);
                        error_count++;
                    end
                    if (res_den !== exp_f.den)
                    begin
                        $error("res_den: expected %0d, actual %0d", exp_f.den, res_den);
                        error_count++;
                    end
                    if (status !== exp_f.st)
                    begin
                        $error("status: expected %0d, actual %0d", exp_f.st, status);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (CycleLimit) @(posedge clk);
        $display("rational_arithmetic_unit_test failed");
        $finish;
    end

    function automatic logic [31:0] small_value();
        return $urandom_range(2000) - 32'd1000;
    endfunction

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_item(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
        send_item(rau_pkg::FUNC_SUB, 1, 2, 1, 3);
        send_item(rau_pkg::FUNC_MUL, -6, 4, 10, -9);
        send_item(rau_pkg::FUNC_DIV, 3, 4, -9, 8);
        send_item(rau_pkg::FUNC_RED, 12, -18, 0, 0);
        send_item(3'd5, 10, 4, 7, 7);
        send_item(3'd6, -7, -7, 1, 1);
        send_item(3'd7, 0, 5, 1, 1);
        send_item(rau_pkg::FUNC_ADD, 1, 0, 1, 1);      // zero denominator
        send_item(rau_pkg::FUNC_RED, 0, 0, 0, 0);      // zero over zero
        send_item(rau_pkg::FUNC_DIV, 1, 1, 0, 1);      // divide by zero fraction
        send_item(rau_pkg::FUNC_SUB, 5, 7, 5, 7);      // zero numerator
        send_item(rau_pkg::FUNC_MUL, mx, 1, mx, 1);    // too wide
        send_item(rau_pkg::FUNC_ADD, mx, 1, mx, 1);
        send_item(rau_pkg::FUNC_SUB, mn, 1, mx, 1);
        send_item(rau_pkg::FUNC_RED, mn, 1, 0, 0);     // most negative still fits
        send_item(rau_pkg::FUNC_RED, mn, -1, 0, 0);    // negation overflows
        send_item(rau_pkg::FUNC_RED, 1, mn, 0, 0);     // denominator too big
        send_item(rau_pkg::FUNC_MUL, mn, mn, mn, mn);
        send_item(rau_pkg::FUNC_ADD, mx, mn, mn, mx);
        send_item(rau_pkg::FUNC_DIV, mx, mx, mx, mx);
        send_item(rau_pkg::FUNC_SUB, -1, -1, -1, -1);
        send_item(rau_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h0F0F_0F0F);
    endtask

    task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
        logic [31:0] v[4];
        logic [31:0] k;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_items)
        begin
            case ($urandom_range(2))
                0:
                    foreach (v[i]) v[i] = $urandom();
                1:
                    foreach (v[i]) v[i] = small_value();
                default:
                begin
                    // shared factors force real reduction
                    k = $urandom_range(1, 300);
                    foreach (v[i]) v[i] = small_value() * k;
                end
            endcase
            if ($urandom_range(19) == 0)
                v[2'($urandom_range(3))] = 0;
            send_item(3'($urandom_range(7)), v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 3000;
        repeat (6)
            send_item(3'($urandom_range(4)), small_value(), small_value(),
                      small_value(), small_value());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        a_num = '0;
        a_den = '0;
        b_num = '0;
        b_den = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        error_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300, 27, 51);
        test_random(300, 51, 27);
        test_backpressure();
        test_random(300, 0, 0);

        in_valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("rational_arithmetic_unit_test passed");
        else
            $display("rational_arithmetic_unit_test failed");
        $finish;
    end

endmodule

// File: rational_arithmetic_unit.f
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_test.sv
